// ===== rtl/core/pairwise_gravity_force_assert.svh =====
// assertion macros for the pairwise gravity force checker
// needs a clk and an active-high rst in the scope where a macro is used
`ifndef PAIRWISE_GRAVITY_FORCE_ASSERT_SVH
`define PAIRWISE_GRAVITY_FORCE_ASSERT_SVH

// same-cycle implication, off during reset
`define PGF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define PGF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// state right after a reset cycle
`define PGF_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/pgf_pkg.sv =====
// types, constants and stage map of the pairwise gravity force pipeline
// no dependencies
package pgf_pkg;

  localparam int ADDR_W = 3;

  typedef enum logic [0:0] {
    REG_GRAV  = 1'b0,
    REG_BOUND = 1'b1
  } reg_idx_t;

  localparam logic [31:0] GRAV_RESET  = 32'd286640;
  localparam logic [30:0] BOUND_RESET = 31'd12800000;

  localparam logic [47:0] FMAX_POS = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] FMAX_NEG = 48'h8000_0000_0000;

  // stage map
  localparam int SQRT_BITS  = 34;
  localparam int QUO_BITS   = 48;
  localparam int STG_ENTRY  = 0;
  localparam int STG_SQUARE = 1;
  localparam int STG_SUM    = 2;
  localparam int STG_GMM    = 3;
  localparam int STG_SQRT0  = 4;
  localparam int STG_NUMP   = STG_SQRT0;
  localparam int STG_NUM    = STG_SQRT0 + 1;
  localparam int STG_DENP   = STG_SQRT0 + SQRT_BITS;
  localparam int STG_DEN    = STG_DENP + 1;
  localparam int STG_OVF    = STG_DEN + 1;
  localparam int STG_DIV0   = STG_OVF + 1;
  localparam int STG_FINAL  = STG_DIV0 + QUO_BITS;
  localparam int NUM_STAGES = STG_FINAL + 1;

  typedef struct packed {
    logic signed [31:0] a_pos_x;
    logic signed [31:0] a_pos_y;
    logic signed [31:0] a_pos_z;
    logic signed [31:0] b_pos_x;
    logic signed [31:0] b_pos_y;
    logic signed [31:0] b_pos_z;
    logic [31:0]        a_mass;
    logic [31:0]        b_mass;
    logic [30:0]        a_radius;
    logic [30:0]        b_radius;
  } pair_t;

  typedef struct packed {
    logic               collided;
    logic               a_outside;
    logic               b_outside;
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
  } force_t;

  typedef struct packed {
    logic                 collided;
    logic                 a_out;
    logic                 b_out;
    logic [2:0]           neg;
    logic [2:0][31:0]     mag;
    logic [31:0]          rs;
    logic [31:0]          g;
    logic [31:0]          ma;
    logic [31:0]          mb;
    logic [2:0][63:0]     sq;
    logic [63:0]          rs2;
    logic [65:0]          s;
    logic [63:0]          gm;
    logic [1:0][63:0]     pp;
    logic [95:0]          gmm;
    logic [2:0][2:0][63:0] np;
    logic [2:0][127:0]    num;
    logic [33:0]          root;
    logic [65:0]          srem;
    logic [1:0][66:0]     dp;
    logic [99:0]          den;
    logic [2:0][99:0]     prem;
    logic [2:0][47:0]     quo;
    logic [2:0]           ovf;
    logic [2:0][47:0]     frc;
  } pipe_t;

endpackage

// ===== rtl/core/pgf_if.sv =====
// stream interfaces for pair items and force results
// depends on pgf_pkg
interface pgf_pair_if;
  logic          valid;
  logic          ready;
  pgf_pkg::pair_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pgf_force_if;
  logic            valid;
  logic            ready;
  pgf_pkg::force_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/pairwise_gravity_force.sv =====
// pairwise gravity force unit: pipelined distance, collision test and force
// depends on pgf_pkg and the stream interfaces in pgf_if
//
//  channel   dir  handshake        transfer carries
//  pairs     in   valid / ready    two positions, masses and radii
//  forces    out  valid / ready    collision and bound flags, force on b
//  apb       in   psel / penable   grav_constant (0x0), bound_limit (0x4)
//
// one pair per clock while the pipe is not frozen; a result passes through the 90 pipeline
// stages and then the output register; the depth is set by the 34-step square root and
// the 48-step quotient, one result bit per stage
// rst is synchronous; it clears the valid bits and sets the registers
// an output register plus a skid register follow the pipe; ready drops only
// while the skid register holds a result, and the whole pipe then freezes
module pairwise_gravity_force (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pgf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  pgf_pair_if.sink                   pairs,
  pgf_force_if.source                forces
);
  import pgf_pkg::*;

  // entry stage: deltas, signs, radius sum, bound checks
  function automatic pipe_t entry_step(input pair_t p, input logic [31:0] g,
                                       input logic [30:0] lim);
    pipe_t              x;
    logic signed [32:0] av [3];
    logic signed [32:0] bv [3];
    logic signed [32:0] d;
    logic signed [32:0] hi;
    logic signed [32:0] lo;
    x = '0;
    av[0] = {p.a_pos_x[31], p.a_pos_x};
    av[1] = {p.a_pos_y[31], p.a_pos_y};
    av[2] = {p.a_pos_z[31], p.a_pos_z};
    bv[0] = {p.b_pos_x[31], p.b_pos_x};
    bv[1] = {p.b_pos_y[31], p.b_pos_y};
    bv[2] = {p.b_pos_z[31], p.b_pos_z};
    hi = {2'b00, lim};
    lo = 33'sd0 - hi;
    for (int i = 0; i < 3; i++) begin
      d = av[i] - bv[i];
      x.neg[i] = d[32];
      x.mag[i] = d[32] ? 32'(33'sd0 - d) : d[31:0];
      x.a_out = x.a_out | (av[i] > hi) | (av[i] < lo);
      x.b_out = x.b_out | (bv[i] > hi) | (bv[i] < lo);
    end
    x.rs = {1'b0, p.a_radius} + {1'b0, p.b_radius};
    x.g  = g;
    x.ma = p.a_mass;
    x.mb = p.b_mass;
    return x;
  endfunction

  // work of pipeline stage k on the item coming from stage k-1
  function automatic pipe_t stage_step(input int k, input pipe_t p);
    pipe_t        x;
    logic [5:0]   bs;
    logic [5:0]   bq;
    logic [69:0]  trial;
    logic [100:0] tr;
    logic [47:0]  qm;
    x = p;
    bs = 6'(STG_DENP - 1 - k);
    bq = 6'(STG_FINAL - 1 - k);
    if (k == STG_SQUARE) begin
      for (int i = 0; i < 3; i++) x.sq[i] = 64'(p.mag[i]) * 64'(p.mag[i]);
      x.rs2 = 64'(p.rs) * 64'(p.rs);
      x.gm  = 64'(p.g) * 64'(p.ma);
    end
    if (k == STG_SUM) begin
      x.s = 66'(p.sq[0]) + 66'(p.sq[1]) + 66'(p.sq[2]);
      x.collided = (x.s <= 66'(p.rs2));
      x.pp[0] = 64'(p.gm[31:0]) * 64'(p.mb);
      x.pp[1] = 64'(p.gm[63:32]) * 64'(p.mb);
    end
    if (k == STG_GMM) begin
      x.gmm  = 96'(p.pp[0]) + (96'(p.pp[1]) << 32);
      x.root = '0;
      x.srem = p.s;
    end
    if (k == STG_NUMP) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          x.np[i][j] = 64'(p.gmm[32*j +: 32]) * 64'(p.mag[i]);
    end
    if (k == STG_NUM) begin
      for (int i = 0; i < 3; i++)
        x.num[i] = 128'(p.np[i][0]) + (128'(p.np[i][1]) << 32) +
                   (128'(p.np[i][2]) << 64);
    end
    // square root, one root bit per stage, remainder kept as s - root^2
    if (k >= STG_SQRT0 && k < STG_DENP) begin
      trial = (70'(p.root) << (7'(bs) + 7'd1)) + (70'd1 << {bs, 1'b0});
      if (trial <= 70'(p.srem)) begin
        x.root = p.root | (34'd1 << bs);
        x.srem = 66'(70'(p.srem) - trial);
      end
    end
    if (k == STG_DENP) begin
      x.dp[0] = 67'(p.s[32:0]) * 67'(p.root);
      x.dp[1] = 67'(p.s[65:33]) * 67'(p.root);
    end
    if (k == STG_DEN) begin
      x.den = 100'(p.dp[0]) + (100'(p.dp[1]) << 33);
    end
    // quotient of num/2^16 by den needs 48 bits unless the top part overflows
    if (k == STG_OVF) begin
      for (int i = 0; i < 3; i++) begin
        x.ovf[i]  = (100'(p.num[i][127:64]) >= p.den);
        x.prem[i] = 100'(p.num[i][127:64]);
        x.quo[i]  = '0;
      end
    end
    if (k >= STG_DIV0 && k < STG_FINAL) begin
      for (int i = 0; i < 3; i++) begin
        tr = {p.prem[i], p.num[i][7'(bq) + 7'd16]};
        if (tr >= 101'(p.den)) begin
          x.prem[i] = 100'(tr - 101'(p.den));
          x.quo[i][bq] = 1'b1;
        end else begin
          x.prem[i] = tr[99:0];
        end
      end
    end
    // saturate, apply sign, clear everything on collision
    if (k == STG_FINAL) begin
      for (int i = 0; i < 3; i++) begin
        if (p.collided) begin
          x.frc[i] = '0;
        end else if (p.neg[i]) begin
          qm = (p.ovf[i] || p.quo[i] > FMAX_NEG) ? FMAX_NEG : p.quo[i];
          x.frc[i] = 48'd0 - qm;
        end else begin
          x.frc[i] = (p.ovf[i] || p.quo[i] > FMAX_POS) ? FMAX_POS : p.quo[i];
        end
      end
      if (p.collided) begin
        x.a_out = 1'b0;
        x.b_out = 1'b0;
      end
    end
    return x;
  endfunction

  // configuration registers
  logic [31:0] grav_constant;
  logic [30:0] bound_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav_constant <= GRAV_RESET;
      bound_limit   <= BOUND_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_GRAV:  grav_constant <= pwdata;
        REG_BOUND: bound_limit   <= pwdata[30:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_GRAV:  prdata = grav_constant;
      REG_BOUND: prdata = {1'b0, bound_limit};
    endcase
  end

  assign pready = 1'b1;

  // pipeline: valid bits travel with the items, all stages move together
  pipe_t                 stg [NUM_STAGES];
  logic [NUM_STAGES-1:0] stg_valid;
  logic                  advance;

  // output register and skid register
  force_t out_item;
  force_t skid_item;
  force_t done_item;
  logic   out_valid;
  logic   skid_valid;
  logic   pop;
  logic   push;

  assign advance     = !skid_valid;
  assign pairs.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
    end else if (advance) begin
      stg_valid <= {stg_valid[NUM_STAGES-2:0], pairs.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stg[0] <= entry_step(pairs.data, grav_constant, bound_limit);
      for (int k = 1; k < NUM_STAGES; k++) stg[k] <= stage_step(k, stg[k-1]);
    end
  end

  assign done_item.collided  = stg[NUM_STAGES-1].collided;
  assign done_item.a_outside = stg[NUM_STAGES-1].a_out;
  assign done_item.b_outside = stg[NUM_STAGES-1].b_out;
  assign done_item.force_x   = stg[NUM_STAGES-1].frc[0];
  assign done_item.force_y   = stg[NUM_STAGES-1].frc[1];
  assign done_item.force_z   = stg[NUM_STAGES-1].frc[2];

  assign pop  = out_valid && forces.ready;
  assign push = advance && stg_valid[NUM_STAGES-1];

  // push implies the skid register is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_item <= skid_item;
      end else if (push) begin
        out_item <= done_item;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_item <= done_item;
      end else begin
        out_item <= done_item;
      end
    end
  end

  assign forces.valid = out_valid;
  assign forces.data  = out_item;

endmodule

// ===== rtl/core/pgf_checker.sv =====
// port-level checks for the pairwise gravity force unit, bound to the top
// depends on pgf_pkg and pairwise_gravity_force_assert.svh
`include "pairwise_gravity_force_assert.svh"

module pgf_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input pgf_pkg::force_t out_data
);
  import pgf_pkg::*;

  `PGF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `PGF_ASSERT_IMP(a_coll_zero, out_valid && out_data.collided, !out_data.a_outside && !out_data.b_outside && out_data.force_x == '0 && out_data.force_y == '0 && out_data.force_z == '0, "collision with force or flags")
  `PGF_ASSERT_IMP(a_ready_low, !in_ready, out_valid, "input blocked with no result held")
  `PGF_ASSERT_IMP(a_ready_fall, $fell(in_ready), $past(out_valid && !out_ready), "input blocked without output stall")
  `PGF_ASSERT_RST(a_reset, !out_valid && in_ready, "bad state after reset")

endmodule

bind pairwise_gravity_force pgf_checker u_pgf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pairs.ready),
  .out_valid (forces.valid),
  .out_ready (forces.ready),
  .out_data  (forces.data)
);
